>>> design/rme_pkg.sv
// Shared types and constants for the rotation matrix engine.
`timescale 1ns / 1ps
package rme_pkg;

  localparam int OP_W = 4;

  localparam logic [OP_W-1:0] OP_IDENT  = 4'd0;
  localparam logic [OP_W-1:0] OP_ROW02  = 4'd1;
  localparam logic [OP_W-1:0] OP_ROW12  = 4'd2;
  localparam logic [OP_W-1:0] OP_ROW01  = 4'd3;
  localparam logic [OP_W-1:0] OP_COL02  = 4'd4;
  localparam logic [OP_W-1:0] OP_COL12  = 4'd5;
  localparam logic [OP_W-1:0] OP_COL01  = 4'd6;
  localparam logic [OP_W-1:0] OP_XFORM  = 4'd7;
  localparam logic [OP_W-1:0] OP_XFORMT = 4'd8;
  localparam logic [OP_W-1:0] OP_RDROW  = 4'd9;
  localparam logic [OP_W-1:0] OP_RDCOL  = 4'd10;

  localparam int ATAN_COUNT = 24;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  typedef struct packed {
    logic [3:0]         operation;
    logic signed [15:0] angle;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic [1:0]         index;
  } rme_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               saturated;
  } rme_out_t;

  typedef struct packed {
    logic       start;
    logic [4:0] steps;
  } rme_cordic_ctl_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] t;
    case (i)
      5'd0:  t = 32'h20000000;
      5'd1:  t = 32'h12E4051E;
      5'd2:  t = 32'h09FB385B;
      5'd3:  t = 32'h051111D4;
      5'd4:  t = 32'h028B0D43;
      5'd5:  t = 32'h0145D7E1;
      5'd6:  t = 32'h00A2F61E;
      5'd7:  t = 32'h00517C55;
      5'd8:  t = 32'h0028BE53;
      5'd9:  t = 32'h00145F2F;
      5'd10: t = 32'h000A2F98;
      5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6;
      5'd13: t = 32'h000145F3;
      5'd14: t = 32'h0000A2FA;
      5'd15: t = 32'h0000517D;
      5'd16: t = 32'h000028BE;
      5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A30;
      5'd19: t = 32'h00000518;
      5'd20: t = 32'h0000028C;
      5'd21: t = 32'h00000146;
      5'd22: t = 32'h000000A3;
      5'd23: t = 32'h00000051;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

endpackage

>>> design/rotation_matrix_engine_unit.sv
// Top level: matrix store and sequencer of the rotation matrix engine.
// Rotations run the CORDIC loop and handoff, 12 single-multiply MAC passes, six writebacks
// and done; transforms run nine MAC passes, three writebacks and done; identity and reads
// go straight to done.
// One item at a time: busy stays high from acceptance through the out_valid cycle.
// Synchronous active-low reset restores the identity matrix and idles the sequencer.
// Results show for one cycle on out_valid; the receiver cannot stall.
`timescale 1ns / 1ps
module rotation_matrix_engine_unit #(
  parameter int MATRIX_WIDTH = 18,
  parameter int VECTOR_WIDTH = 32,
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rme_pkg::rme_in_t  in_word,
  output logic              out_valid,
  output rme_pkg::rme_out_t out_word
);
  import rme_pkg::*;

  localparam int MW = MATRIX_WIDTH;
  localparam int MF = MW - 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CORD = 3'd1;
  localparam logic [2:0] S_MAC  = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]          st_r, st_nxt;
  rme_in_t             in_r;
  logic signed [MW-1:0] m_r [9];
  logic signed [MW-1:0] c_r, s_r;
  logic [3:0]          k_r, k_nxt;
  logic [1:0]          t_r, t_nxt;
  logic                flag_r, flag_nxt;
  logic signed [31:0]  r_r [3];
  logic                go;
  rme_cordic_ctl_t     cctl;
  logic                cdone;
  logic signed [MW-1:0] cq, sq;
  logic                mclr, men, mvec;
  logic signed [MW-1:0] ma;
  logic signed [33:0]  mb;
  logic signed [31:0]  mres;
  logic                mclip;
  logic                is_rot, cols, minus_first;
  logic [3:0]          ia, ib, pa, pb;
  logic [1:0]          idx;
  logic [1:0]          kk;
  logic signed [MW-1:0] se, va, vb;
  logic [3:0]          mi;
  logic signed [31:0]  vv;

  assign go = start && !busy;
  assign is_rot = (in_r.operation >= OP_ROW02) && (in_r.operation <= OP_COL01);
  assign cols = (in_r.operation >= OP_COL02);
  assign idx = (in_r.index == 2'd3) ? 2'd2 : in_r.index;

  always_comb begin
    ia = 4'd0;
    ib = 4'd2;
    minus_first = 1'b0;
    case (in_r.operation)
      OP_ROW02, OP_COL02: begin
        ia = 4'd0; ib = 4'd2; minus_first = 1'b1;
      end
      OP_ROW12, OP_COL12: begin
        ia = 4'd1; ib = 4'd2;
      end
      OP_ROW01, OP_COL01: begin
        ia = 4'd0; ib = 4'd1;
      end
      default: begin
        ia = 4'd0; ib = 4'd2;
      end
    endcase
  end

  // rotation: k_r = element (0..2), t_r = 0,1 for a', 2,3 for b'
  assign kk = k_r[1:0];
  always_comb begin
    if (cols) begin
      pa = 4'(kk * 3) + ia;
      pb = 4'(kk * 3) + ib;
    end else begin
      pa = 4'(ia * 3) + {2'b00, kk};
      pb = 4'(ib * 3) + {2'b00, kk};
    end
    se = minus_first ? -s_r : s_r;
    va = m_r[pa];
    vb = m_r[pb];
    ma = c_r;
    mb = '0;
    case (t_r)
      2'd0: begin ma = c_r; mb = 34'(va); end
      2'd1: begin ma = se;  mb = 34'(vb); end
      2'd2: begin ma = c_r; mb = 34'(vb); end
      default: begin ma = -se; mb = 34'(va); end
    endcase
    mi = (in_r.operation == OP_XFORM) ? 4'(k_r[1:0] * 3) + {2'b00, t_r}
                                      : 4'(t_r * 3) + {2'b00, k_r[1:0]};
    case (t_r)
      2'd0: vv = in_r.vec_x;
      2'd1: vv = in_r.vec_y;
      default: vv = in_r.vec_z;
    endcase
    if (!is_rot) begin
      ma = m_r[mi];
      mb = 34'(vv);
    end
  end

  assign cctl.start = go && (in_word.operation >= OP_ROW02) && (in_word.operation <= OP_COL01);
  assign cctl.steps = 5'(CORDIC_STEPS);

  rme_cordic #(.MW(MW)) u_cordic (
    .clk(clk), .rst_n(rst_n), .ctl(cctl), .angle(in_word.angle),
    .done(cdone), .cos_q(cq), .sin_q(sq)
  );

  assign mclr = (st_r != S_MAC);
  assign men  = (st_r == S_MAC);
  assign mvec = !is_rot;

  rme_mac #(.MW(MW), .VW(VECTOR_WIDTH)) u_mac (
    .clk(clk), .clear(mclr), .acc_en(men), .mul_a(ma), .mul_b(mb),
    .to_vec(mvec), .result(mres), .clipped(mclip)
  );

  always_comb begin
    st_nxt   = st_r;
    k_nxt    = k_r;
    t_nxt    = t_r;
    flag_nxt = flag_r;
    case (st_r)
      S_IDLE: begin
        if (go) begin
          k_nxt = '0;
          t_nxt = '0;
          flag_nxt = 1'b0;
          if (in_word.operation >= OP_ROW02 && in_word.operation <= OP_COL01) begin
            st_nxt = S_CORD;
          end else if (in_word.operation == OP_XFORM || in_word.operation == OP_XFORMT) begin
            st_nxt = S_MAC;
          end else if (in_word.operation <= OP_RDCOL) begin
            st_nxt = S_DONE;
          end
        end
      end
      S_CORD: begin
        if (cdone) begin
          st_nxt = S_MAC;
        end
      end
      S_MAC: begin
        // advance one product; every term group ends in a writeback
        if (is_rot) begin
          if (t_r[0]) begin
            st_nxt = S_WB;
          end else begin
            t_nxt = t_r + 2'd1;
          end
        end else begin
          if (t_r == 2'd2) begin
            st_nxt = S_WB;
          end else begin
            t_nxt = t_r + 2'd1;
          end
        end
      end
      S_WB: begin
        flag_nxt = flag_r | mclip;
        st_nxt = S_MAC;
        if (is_rot) begin
          if (t_r == 2'd3) begin
            t_nxt = '0;
            k_nxt = k_r + 4'd1;
            if (k_r == 4'd2) begin
              st_nxt = S_DONE;
            end
          end else begin
            t_nxt = t_r + 2'd1;
          end
        end else begin
          t_nxt = '0;
          k_nxt = k_r + 4'd1;
          if (k_r == 4'd2) begin
            st_nxt = S_DONE;
          end
        end
      end
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // rotation writes a' and b' only after both are computed: hold a' in r_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      flag_r <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        m_r[i] <= (i % 4 == 0) ? (MW'(1) <<< MF) : '0;
      end
    end else begin
      st_r   <= st_nxt;
      flag_r <= flag_nxt;
      if (go) begin
        in_r <= in_word;
      end
      if (st_r == S_CORD && cdone) begin
        c_r <= cq;
        s_r <= sq;
      end
      if (st_r == S_IDLE && go && in_word.operation == OP_IDENT) begin
        for (int i = 0; i < 9; i++) begin
          m_r[i] <= (i % 4 == 0) ? (MW'(1) <<< MF) : '0;
        end
      end
      if (st_r == S_WB) begin
        if (is_rot) begin
          if (t_r == 2'd1) begin
            r_r[0] <= mres;
          end else begin
            m_r[pa] <= r_r[0][MW-1:0];
            m_r[pb] <= mres[MW-1:0];
          end
        end else begin
          r_r[k_r[1:0]] <= mres;
        end
      end
      if (st_r == S_IDLE && go) begin
        r_r[0] <= '0;
        r_r[1] <= '0;
        r_r[2] <= '0;
      end
      if (st_r == S_DONE) begin
        if (in_r.operation == OP_RDROW) begin
          for (int j = 0; j < 3; j++) begin
            r_r[j] <= 32'(m_r[4'(idx * 3) + 4'(j)]);
          end
        end else if (in_r.operation == OP_RDCOL) begin
          for (int j = 0; j < 3; j++) begin
            r_r[j] <= 32'(m_r[4'(j * 3) + {2'b00, idx}]);
          end
        end else if (is_rot) begin
          r_r[0] <= '0;
        end
      end
    end
    k_r <= k_nxt;
    t_r <= t_nxt;
  end

  logic ov_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= (st_r == S_DONE);
    end
  end

  assign busy      = (st_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_word.out_x = r_r[0];
  assign out_word.out_y = r_r[1];
  assign out_word.out_z = r_r[2];
  assign out_word.saturated = flag_r;

endmodule

>>> design/rme_cordic.sv
// Iterative CORDIC sine and cosine, one micro-rotation per cycle.
`timescale 1ns / 1ps
module rme_cordic #(
  parameter int MW = 18
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rme_pkg::rme_cordic_ctl_t  ctl,
  input  logic signed [15:0]        angle,
  output logic                      done,
  output logic signed [MW-1:0]      cos_q,
  output logic signed [MW-1:0]      sin_q
);
  import rme_pkg::*;

  localparam int MF = MW - 2;

  logic signed [33:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [33:0] z_r, z_nxt;
  logic               neg_r, neg_nxt;
  logic [4:0]         i_r, i_nxt;
  logic [4:0]         n_r, n_nxt;
  logic               run_r, run_nxt;
  logic               done_r, done_nxt;
  logic signed [33:0] z0;
  logic signed [33:0] dx, dy, at;

  function automatic logic signed [MW-1:0] fin(input logic signed [33:0] v,
                                               input logic ng);
    logic signed [35:0] t;
    logic signed [35:0] hi;
    t = {{2{v[33]}}, v};
    if (30 - MF > 0) begin
      t = (t + (36'sd1 <<< (29 - MF))) >>> (30 - MF);
    end else begin
      t = t <<< (MF - 30);
    end
    if (ng) begin
      t = -t;
    end
    hi = (36'sd1 <<< (MW - 1)) - 36'sd1;
    if (t > hi) begin
      t = hi;
    end else if (t < -hi - 36'sd1) begin
      t = -hi - 36'sd1;
    end
    return t[MW-1:0];
  endfunction

  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;
  assign at = {2'b00, atan_entry(i_r)};
  assign z0 = {{2{angle[15]}}, angle, 16'h0};

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    neg_nxt  = neg_r;
    i_nxt    = i_r;
    n_nxt    = n_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      x_nxt   = CORDIC_X0;
      y_nxt   = '0;
      i_nxt   = '0;
      n_nxt   = ctl.steps;
      run_nxt = 1'b1;
      neg_nxt = 1'b0;
      z_nxt   = z0;
      if (z0 > 34'sd1073741824) begin
        z_nxt   = z0 - 34'sd2147483648;
        neg_nxt = 1'b1;
      end else if (z0 < -34'sd1073741824) begin
        z_nxt   = z0 + 34'sd2147483648;
        neg_nxt = 1'b1;
      end
    end else if (run_r) begin
      if (!z_r[33]) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + at;
      end
      i_nxt = i_r + 5'd1;
      if (i_r + 5'd1 == n_r) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    neg_r <= neg_nxt;
    i_r   <= i_nxt;
    n_r   <= n_nxt;
  end

  assign done  = done_r;
  assign cos_q = fin(x_r, neg_r);
  assign sin_q = fin(y_r, neg_r);

endmodule

>>> design/rme_mac.sv
// Shared multiply-accumulate unit with rounding and saturation.
`timescale 1ns / 1ps
module rme_mac #(
  parameter int MW = 18,
  parameter int VW = 32
) (
  input  logic                 clk,
  input  logic                 clear,
  input  logic                 acc_en,
  input  logic signed [MW-1:0] mul_a,
  input  logic signed [33:0]   mul_b,
  input  logic                 to_vec,
  output logic signed [31:0]   result,
  output logic                 clipped
);
  import rme_pkg::*;

  localparam int MF = MW - 2;
  localparam int VB = (VW < 32) ? VW : 32;
  localparam int PW = MW + 34;
  localparam int AW = PW + 2;
  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (MF - 1);

  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] rnd;
  logic signed [AW-1:0] hi;
  int                   bits;

  assign prod = mul_a * mul_b;

  always_comb begin
    acc_nxt = acc_r;
    if (clear) begin
      acc_nxt = '0;
    end else if (acc_en) begin
      acc_nxt = acc_r + {{(AW-PW){prod[PW-1]}}, prod};
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  always_comb begin
    bits = to_vec ? VB : MW;
    rnd  = (acc_r + HALF) >>> MF;
    hi   = ({{(AW-1){1'b0}}, 1'b1} <<< (bits - 1)) - 1;
    clipped = 1'b0;
    result  = rnd[31:0];
    if (rnd > hi) begin
      clipped = 1'b1;
      result  = hi[31:0];
    end else if (rnd < -hi - 1) begin
      clipped = 1'b1;
      result  = 32'(-hi - 1);
    end
  end

endmodule

>>> design/rme_checker.sv
// Port-level assertions for the rotation matrix engine, bound to the top level.
`timescale 1ns / 1ps
module rme_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [3:0] operation,
  input logic       out_valid
);
  import rme_pkg::*;

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && operation <= OP_RDCOL) |=> busy)
    else $error("busy not raised after accept");

  a_valid_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than a cycle");

  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result shown while idle");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");

endmodule

bind rotation_matrix_engine_unit rme_checker u_rme_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .operation(in_word.operation), .out_valid(out_valid)
);

>>> bench/rotation_matrix_engine_unit_tb.sv
// Self-checking bench for the rotation matrix engine: directed and random commands, live prediction.
`timescale 1ns / 1ps
module rotation_matrix_engine_unit_tb;
  import rme_pkg::*;

  localparam int MW = 18;
  localparam int MF = MW - 2;
  localparam int STEPS = 16;
  localparam int N_RANDOM = 500;
  localparam int CALM_TAIL = 100;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd11;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  rme_in_t in_word;
  logic out_valid;
  rme_out_t out_word;

  rotation_matrix_engine_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_word(in_word), .out_valid(out_valid), .out_word(out_word)
  );

  longint mtx[9];
  rme_out_t pending_words[$];
  bit failed;
  int idle_cycles;
  bit allow_gaps;

  const longint atan_q30[16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  function automatic longint clip(longint v, int bits, ref bit flag);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      flag = 1'b1;
      return hi;
    end
    if (v < lo) begin
      flag = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic longint round_q(longint sum);
    return (sum + (64'sd1 <<< (MF - 1))) >>> MF;
  endfunction

  task automatic load_identity();
    for (int i = 0; i < 9; i++) mtx[i] = (i % 4 == 0) ? (64'sd1 <<< MF) : 64'sd0;
  endtask

  task automatic sin_cos(input logic signed [15:0] ang, output longint c, output longint s);
    longint z;
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit neg;
    bit unused;
    z = longint'(ang) * 65536;
    x = 652032874;
    y = 0;
    neg = 0;
    if (z > (64'sd1 <<< 30)) begin
      z -= (64'sd1 <<< 31);
      neg = 1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z += (64'sd1 <<< 31);
      neg = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q30[i];
      end else begin
        x += dx; y -= dy; z += atan_q30[i];
      end
    end
    x = (x + (64'sd1 <<< (29 - MF))) >>> (30 - MF);
    y = (y + (64'sd1 <<< (29 - MF))) >>> (30 - MF);
    if (neg) begin
      x = -x; y = -y;
    end
    c = clip(x, MW, unused);
    s = clip(y, MW, unused);
  endtask

  task automatic rotate_pair(bit cols, int ia, int ib, bit minus_first,
                             logic signed [15:0] ang, ref bit flag);
    longint c;
    longint s;
    longint a;
    longint b;
    int pa;
    int pb;
    sin_cos(ang, c, s);
    if (minus_first) s = -s;
    for (int k = 0; k < 3; k++) begin
      pa = cols ? k * 3 + ia : ia * 3 + k;
      pb = cols ? k * 3 + ib : ib * 3 + k;
      a = mtx[pa];
      b = mtx[pb];
      mtx[pa] = clip(round_q(c * a + s * b), MW, flag);
      mtx[pb] = clip(round_q(c * b - s * a), MW, flag);
    end
  endtask

  task automatic predict_word(input rme_in_t w);
    rme_out_t r;
    bit flag;
    longint v[3];
    longint acc;
    int idx;
    flag = 0;
    r = '0;
    v[0] = w.vec_x; v[1] = w.vec_y; v[2] = w.vec_z;
    idx = (w.index > 2) ? 2 : int'(w.index);
    case (w.operation)
      OP_IDENT: load_identity();
      OP_ROW02: rotate_pair(0, 0, 2, 1, w.angle, flag);
      OP_ROW12: rotate_pair(0, 1, 2, 0, w.angle, flag);
      OP_ROW01: rotate_pair(0, 0, 1, 0, w.angle, flag);
      OP_COL02: rotate_pair(1, 0, 2, 1, w.angle, flag);
      OP_COL12: rotate_pair(1, 1, 2, 0, w.angle, flag);
      OP_COL01: rotate_pair(1, 0, 1, 0, w.angle, flag);
      OP_XFORM, OP_XFORMT: begin
        for (int k = 0; k < 3; k++) begin
          acc = 0;
          for (int j = 0; j < 3; j++)
            acc += ((w.operation == OP_XFORM) ? mtx[k * 3 + j] : mtx[j * 3 + k]) * v[j];
          acc = clip(round_q(acc), 32, flag);
          if (k == 0) r.out_x = acc[31:0];
          else if (k == 1) r.out_y = acc[31:0];
          else r.out_z = acc[31:0];
        end
      end
      OP_RDROW: begin
        r.out_x = mtx[idx * 3][31:0];
        r.out_y = mtx[idx * 3 + 1][31:0];
        r.out_z = mtx[idx * 3 + 2][31:0];
      end
      OP_RDCOL: begin
        r.out_x = mtx[idx][31:0];
        r.out_y = mtx[3 + idx][31:0];
        r.out_z = mtx[6 + idx][31:0];
      end
      default: return;
    endcase
    r.saturated = flag;
    pending_words.push_back(r);
  endtask

  // hold start high across back-to-back words; it is dropped here at random when allow_gaps is set
  task automatic send_word(input rme_in_t w);
    int gap;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    @(posedge clk iff !busy);
    predict_word(w);
  endtask

  task automatic pause_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic rme_in_t make_word(logic [3:0] op, logic signed [15:0] ang,
                                        logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                        logic [1:0] idx);
    rme_in_t w;
    w.operation = op; w.angle = ang;
    w.vec_x = x; w.vec_y = y; w.vec_z = z; w.index = idx;
    return w;
  endfunction

  function automatic logic [31:0] rand_vec_comp();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  task automatic test_reads_after_reset();
    for (int i = 0; i < 4; i++) send_word(make_word(OP_RDROW, '0, '0, '0, '0, 2'(i)));
    send_word(make_word(OP_RDCOL, '0, '0, '0, '0, 2'd3));
  endtask

  task automatic test_rotations();
    send_word(make_word(OP_ROW02, 16'sd16384, '1, '1, '1, 2'd0));
    send_word(make_word(OP_ROW12, 16'sh8000, '0, '0, '0, 2'd3));
    send_word(make_word(OP_ROW01, 16'sd32767, '0, '0, '0, 2'd0));
    send_word(make_word(OP_COL02, -16'sd16384, '0, '0, '0, 2'd0));
    send_word(make_word(OP_COL12, -16'sd16385, '0, '0, '0, 2'd0));
    send_word(make_word(OP_COL01, 16'sd0, '0, '0, '0, 2'd0));
    send_word(make_word(OP_COL01, 16'sd5461, '0, '0, '0, 2'd0));
    send_word(make_word(OP_RDCOL, '0, '0, '0, '0, 2'd0));
    send_word(make_word(OP_RDROW, '0, '0, '0, '0, 2'd1));
  endtask

  task automatic test_transforms();
    send_word(make_word(OP_XFORM, '0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 2'd0));
    send_word(make_word(OP_XFORMT, '0, 32'h80000000, 32'h80000000, 32'h80000000, 2'd0));
    send_word(make_word(OP_XFORM, '0, 32'h00010000, 32'hFFFF0000, 32'h00008000, 2'd0));
    send_word(make_word(OP_UNUSED_LO, 16'sd100, '1, '1, '1, 2'd3));
    send_word(make_word(OP_UNUSED_HI, 16'sd100, '1, '1, '1, 2'd3));
    send_word(make_word(OP_IDENT, '1, '1, '1, '1, 2'd3));
    send_word(make_word(OP_XFORMT, '0, 32'h12345678, 32'h87654321, 32'h0000FFFF, 2'd0));
  endtask

  task automatic test_random_mix();
    int sent;
    int pick;
    logic [3:0] op;
    sent = 0;
    while (sent < N_RANDOM) begin
      allow_gaps = (sent < N_RANDOM - CALM_TAIL);
      if (sent == N_RANDOM / 3) begin
        start <= 1'b0;
        wait (pending_words.size() == 0);
        @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) op = OP_IDENT;
      else if (pick < 45) op = 4'($urandom_range(OP_ROW02, OP_COL01));
      else if (pick < 70) op = $urandom_range(0, 1) ? OP_XFORM : OP_XFORMT;
      else if (pick < 94) op = $urandom_range(0, 1) ? OP_RDROW : OP_RDCOL;
      else op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      send_word(make_word(op, 16'($urandom), rand_vec_comp(), rand_vec_comp(),
                          rand_vec_comp(), 2'($urandom_range(0, 3))));
      if (op < OP_UNUSED_LO) sent++;
    end
    pause_start();
  endtask

  always @(posedge clk) begin
    rme_out_t want;
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, out_word);
        failed <= 1'b1;
      end else begin
        want = pending_words.pop_front();
        if (out_word.out_x !== want.out_x)
          $display("%0t: out_x expected %h actual %h", $time, want.out_x, out_word.out_x);
        if (out_word.out_y !== want.out_y)
          $display("%0t: out_y expected %h actual %h", $time, want.out_y, out_word.out_y);
        if (out_word.out_z !== want.out_z)
          $display("%0t: out_z expected %h actual %h", $time, want.out_z, out_word.out_z);
        if (out_word.saturated !== want.saturated)
          $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                   out_word.saturated);
        if (out_word !== want) failed <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    failed = 0;
    idle_cycles = 0;
    allow_gaps = 1;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    load_identity();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reads_after_reset();
    test_rotations();
    test_transforms();
    test_random_mix();
    wait (pending_words.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && pending_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
